### sv/bfsp_pkg.sv
// Shared types and constants of the shortest-path unit.
package bfsp_pkg;

    localparam int VERTEX_W   = 6;
    localparam int DIST_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_EDGE,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

endpackage

### sv/bellman_ford_shortest_paths_unit.sv
// Bellman-Ford shortest-path unit: edge store, distance store and relaxation sequencer.
//
//  channel   direction  beat                                        handshake
//  s_*       in         one edge; tlast marks the final edge        s_tvalid & s_tready
//  m_*       out        one vertex result; tlast on the last one    m_tvalid & m_tready
//  cfg_*     in         register write (index, data)                cfg_valid & cfg_ready
//
// Sequence: edges load at one beat per cycle. A run then takes a set-up state, then visits
//   ST_EDGE and ST_RELAX for each edge in each of n passes (n-1 relaxing, one check),
//   so that the edge-memory read is followed by the distance-memory read.
//   Each result takes a distance-memory read (ST_OUT_RD), then the output register (ST_OUT_WR).
// Reset: aresetn low at a clock edge clears control state, the edge count and the
//   reached flags; vertex_count returns to 64 and source_vertex to 0.
// Stalls: s_tready is high only while loading; a stalled m_* beat holds the result
//   sequencer, and loading of the next graph may start while the last result waits.
module bellman_ford_shortest_paths_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // src_vertex[5:0], dst_vertex[11:6], edge_weight[12+WEIGHT_BITS-1:12], zero pad
    input  logic [((12+WEIGHT_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                  s_tlast,     // last_edge
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vertex_index[5:0], distance[37:6], zero pad [39:38]
    output logic [bfsp_pkg::M_TDATA_W-1:0]        m_tdata,
    // reachable[0], negative_cycle[1]
    output logic [bfsp_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                  m_tlast,     // last_result
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bfsp_pkg::COUNT_W-1:0]          cfg_data
);

    localparam int EDGE_W = 2 * bfsp_pkg::VERTEX_W + WEIGHT_BITS;
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ET_W   = $clog2(MAX_EDGES + 1);
    localparam int VI_W   = $clog2(MAX_VERTICES);
    localparam int VC_W   = $clog2(MAX_VERTICES + 1);
    localparam int VW     = bfsp_pkg::VERTEX_W;
    localparam int DW     = bfsp_pkg::DIST_W;

    // storage
    logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
    logic [DW-1:0]           dist_mem [MAX_VERTICES];

    // registers
    bfsp_pkg::state_t        state_reg, state_next;
    logic [bfsp_pkg::COUNT_W-1:0] vertex_count_reg;
    logic [VW-1:0]           source_vertex_reg;
    logic [ET_W-1:0]         edge_total_reg, edge_total_next;
    logic [ET_W-1:0]         edge_idx_reg, edge_idx_next;
    logic [VC_W-1:0]         n_reg, n_next;
    logic [VC_W-1:0]         pass_reg, pass_next;
    logic [VC_W-1:0]         out_idx_reg, out_idx_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic                    cycle_found_reg, cycle_found_next;
    logic [VI_W-1:0]         e_to_reg, e_to_next;
    logic [WEIGHT_BITS-1:0]  e_weight_reg, e_weight_next;
    logic                    e_ok_reg, e_ok_next;
    logic                    reach_to_reg, reach_to_next;
    logic [EDGE_W-1:0]       edge_rdata_reg;
    logic [DW-1:0]           dist_a_reg, dist_b_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [bfsp_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [bfsp_pkg::M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic                    m_last_reg, m_last_next;

    // memory controls
    logic                    edge_wr_en;
    logic                    edge_rd_en;
    logic [EA_W-1:0]         edge_rd_addr;
    logic                    dist_rd_en;
    logic [VI_W-1:0]         dist_rd_addr_a, dist_rd_addr_b;
    logic                    dist_wr_en;
    logic [VI_W-1:0]         dist_wr_addr;
    logic [DW-1:0]           dist_wr_data;

    // datapath
    logic                    s_beat;
    logic                    m_free;
    logic [VC_W-1:0]         n_clamp;
    logic [VW-1:0]           f_from, f_to;
    logic                    f_in_range;
    logic [DW:0]             sum_wide;
    logic [DW:0]             w_ext;
    logic [DW-1:0]           cand;
    logic                    improve;
    logic                    last_edge_of_pass;
    logic                    last_pass;
    logic                    last_out;

    assign s_tready  = (state_reg == bfsp_pkg::ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;

    assign s_beat = s_tvalid && s_tready;
    assign m_free = !m_valid_reg || m_tready;

    // effective vertex count: 0 acts as 1, above capacity acts as capacity
    always_comb begin
        if (vertex_count_reg == '0) begin
            n_clamp = VC_W'(1);
        end else if (32'(vertex_count_reg) > MAX_VERTICES) begin
            n_clamp = VC_W'(MAX_VERTICES);
        end else begin
            n_clamp = VC_W'(vertex_count_reg);
        end
    end

    // fetched edge fields
    assign f_from     = edge_rdata_reg[VW-1:0];
    assign f_to       = edge_rdata_reg[2*VW-1:VW];
    assign f_in_range = (32'(f_from) < 32'(n_reg)) && (32'(f_to) < 32'(n_reg));

    // saturating candidate distance and improvement test
    assign w_ext    = {{(DW+1-WEIGHT_BITS){e_weight_reg[WEIGHT_BITS-1]}}, e_weight_reg};
    assign sum_wide = {dist_a_reg[DW-1], dist_a_reg} + w_ext;
    always_comb begin
        if (sum_wide[DW] != sum_wide[DW-1]) begin
            cand = sum_wide[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
        end else begin
            cand = sum_wide[DW-1:0];
        end
    end
    assign improve = e_ok_reg && (!reach_to_reg || ($signed(cand) < $signed(dist_b_reg)));

    assign last_edge_of_pass = (ET_W'(edge_idx_reg + 1'b1) == edge_total_reg);
    assign last_pass         = (pass_reg == n_reg);
    assign last_out          = (VC_W'(out_idx_reg + 1'b1) == n_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfsp_pkg::ST_LOAD: begin
                if (s_beat && s_tlast) begin
                    state_next = bfsp_pkg::ST_INIT;
                end
            end
            bfsp_pkg::ST_INIT: begin
                state_next = bfsp_pkg::ST_EDGE;
            end
            bfsp_pkg::ST_EDGE: begin
                state_next = bfsp_pkg::ST_RELAX;
            end
            bfsp_pkg::ST_RELAX: begin
                if (last_edge_of_pass && last_pass) begin
                    state_next = bfsp_pkg::ST_OUT_RD;
                end else begin
                    state_next = bfsp_pkg::ST_EDGE;
                end
            end
            bfsp_pkg::ST_OUT_RD: begin
                state_next = bfsp_pkg::ST_OUT_WR;
            end
            bfsp_pkg::ST_OUT_WR: begin
                if (m_free) begin
                    state_next = last_out ? bfsp_pkg::ST_LOAD : bfsp_pkg::ST_OUT_RD;
                end
            end
            default: begin
                state_next = bfsp_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        edge_total_next  = edge_total_reg;
        edge_idx_next    = edge_idx_reg;
        n_next           = n_reg;
        pass_next        = pass_reg;
        out_idx_next     = out_idx_reg;
        reached_next     = reached_reg;
        cycle_found_next = cycle_found_reg;
        e_to_next        = e_to_reg;
        e_weight_next    = e_weight_reg;
        e_ok_next        = e_ok_reg;
        reach_to_next    = reach_to_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;
        m_last_next      = m_last_reg;
        edge_wr_en       = 1'b0;
        edge_rd_en       = 1'b0;
        dist_rd_en       = 1'b0;
        dist_rd_addr_a   = VI_W'(f_from);
        dist_rd_addr_b   = VI_W'(f_to);
        dist_wr_en       = 1'b0;
        dist_wr_addr     = e_to_reg;
        dist_wr_data     = cand;

        case (state_reg)
            bfsp_pkg::ST_LOAD: begin
                // edges beyond capacity are dropped; the last one still starts a run
                if (s_beat && (32'(edge_total_reg) < MAX_EDGES)) begin
                    edge_wr_en      = 1'b1;
                    edge_total_next = ET_W'(edge_total_reg + 1'b1);
                end
            end
            bfsp_pkg::ST_INIT: begin
                n_next           = n_clamp;
                pass_next        = VC_W'(1);
                edge_idx_next    = '0;
                edge_rd_en       = 1'b1;
                cycle_found_next = 1'b0;
                reached_next     = '0;
                if (32'(source_vertex_reg) < 32'(n_clamp)) begin
                    reached_next[VI_W'(source_vertex_reg)] = 1'b1;
                    dist_wr_en   = 1'b1;
                    dist_wr_addr = VI_W'(source_vertex_reg);
                    dist_wr_data = '0;
                end
            end
            bfsp_pkg::ST_EDGE: begin
                // the last write (from ST_INIT or ST_RELAX) has already landed, so these reads see it
                dist_rd_en    = 1'b1;
                e_to_next     = VI_W'(f_to);
                e_weight_next = edge_rdata_reg[EDGE_W-1:2*VW];
                e_ok_next     = f_in_range && reached_reg[VI_W'(f_from)];
                reach_to_next = reached_reg[VI_W'(f_to)];
            end
            bfsp_pkg::ST_RELAX: begin
                if (!last_pass) begin
                    if (improve) begin
                        dist_wr_en             = 1'b1;
                        reached_next[e_to_reg] = 1'b1;
                    end
                end else if (improve) begin
                    cycle_found_next = 1'b1;
                end
                if (last_edge_of_pass) begin
                    edge_idx_next = '0;
                    if (last_pass) begin
                        out_idx_next = '0;
                    end else begin
                        pass_next  = VC_W'(pass_reg + 1'b1);
                        edge_rd_en = 1'b1;
                    end
                end else begin
                    edge_idx_next = ET_W'(edge_idx_reg + 1'b1);
                    edge_rd_en    = 1'b1;
                end
            end
            bfsp_pkg::ST_OUT_RD: begin
                dist_rd_en     = 1'b1;
                dist_rd_addr_a = VI_W'(out_idx_reg);
            end
            bfsp_pkg::ST_OUT_WR: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(bfsp_pkg::M_TDATA_W-DW-VW){1'b0}},
                                    (reached_reg[VI_W'(out_idx_reg)] ? dist_a_reg : '0),
                                    VW'(out_idx_reg)};
                    m_user_next  = {cycle_found_reg, reached_reg[VI_W'(out_idx_reg)]};
                    m_last_next  = last_out;
                    if (last_out) begin
                        edge_total_next = '0;
                    end else begin
                        out_idx_next = VC_W'(out_idx_reg + 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign edge_rd_addr = edge_idx_next[EA_W-1:0];

    // edge memory
    always_ff @(posedge aclk) begin
        if (edge_wr_en) begin
            edge_mem[edge_total_reg[EA_W-1:0]] <= s_tdata[EDGE_W-1:0];
        end
        if (edge_rd_en) begin
            edge_rdata_reg <= edge_mem[edge_rd_addr];
        end
    end

    // distance memory: one write, two reads
    always_ff @(posedge aclk) begin
        if (dist_wr_en) begin
            dist_mem[dist_wr_addr] <= dist_wr_data;
        end
        if (dist_rd_en) begin
            dist_a_reg <= dist_mem[dist_rd_addr_a];
            dist_b_reg <= dist_mem[dist_rd_addr_b];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg  <= bfsp_pkg::COUNT_W'(64);
            source_vertex_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bfsp_pkg::CFG_VERTEX_COUNT: begin
                    vertex_count_reg <= cfg_data;
                end
                bfsp_pkg::CFG_SOURCE_VERTEX: begin
                    source_vertex_reg <= cfg_data[VW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bfsp_pkg::ST_LOAD;
            edge_total_reg  <= '0;
            edge_idx_reg    <= '0;
            n_reg           <= VC_W'(1);
            pass_reg        <= '0;
            out_idx_reg     <= '0;
            reached_reg     <= '0;
            cycle_found_reg <= 1'b0;
            e_ok_reg        <= 1'b0;
            reach_to_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            edge_total_reg  <= edge_total_next;
            edge_idx_reg    <= edge_idx_next;
            n_reg           <= n_next;
            pass_reg        <= pass_next;
            out_idx_reg     <= out_idx_next;
            reached_reg     <= reached_next;
            cycle_found_reg <= cycle_found_next;
            e_ok_reg        <= e_ok_next;
            reach_to_reg    <= reach_to_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        e_to_reg     <= e_to_next;
        e_weight_reg <= e_weight_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

endmodule

### test/tb_bellman_ford_shortest_paths_unit.sv
// Self-checking testbench for the Bellman-Ford shortest-path unit.
`timescale 1ns / 100ps

module tb_bellman_ford_shortest_paths_unit;

    localparam int MAX_VERTICES   = 64;
    localparam int MAX_EDGES      = 1024;
    localparam int WEIGHT_BITS    = 16;
    localparam int S_TDATA_W      = ((12 + WEIGHT_BITS + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 40;
    localparam int PHASE_ITEMS    = 60;

    typedef enum logic {ROW_CFG, ROW_EDGE} row_kind_t;

    // one row of the directed table; typed rows carry the result for every vertex
    typedef struct packed {
        row_kind_t                          kind;
        logic [bfsp_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [bfsp_pkg::COUNT_W-1:0]       reg_val;
        logic [bfsp_pkg::VERTEX_W-1:0]      from_v;
        logic [bfsp_pkg::VERTEX_W-1:0]      to_v;
        logic [15:0]                        wt;
        logic                               last;
        logic                               typed;
        logic signed [bfsp_pkg::DIST_W-1:0] t_dist;
        logic                               t_reach;
        logic                               t_cycle;
    } stim_row_t;

    typedef struct {
        logic [bfsp_pkg::VERTEX_W-1:0]      vtx;
        logic signed [bfsp_pkg::DIST_W-1:0] plen;
        logic                               reach;
        logic                               cycle;
        logic                               last;
    } vertex_result_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    // src_vertex[5:0], dst_vertex[11:6], edge_weight[27:12], zero pad
    logic [S_TDATA_W-1:0]              s_tdata   = '0;
    logic                              s_tlast   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    // vertex_index[5:0], distance[37:6], zero pad
    logic [bfsp_pkg::M_TDATA_W-1:0]    m_tdata;
    // reachable[0], negative_cycle[1]
    logic [bfsp_pkg::M_TUSER_W-1:0]    m_tuser;
    logic                              m_tlast;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b1;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [bfsp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [bfsp_pkg::COUNT_W-1:0]      cfg_data  = '0;

    // shadow of the block: registers, edge list and per-run distances
    logic [bfsp_pkg::COUNT_W-1:0]       count_reg  = 7'd64;
    logic [bfsp_pkg::VERTEX_W-1:0]      source_reg = '0;
    logic [bfsp_pkg::VERTEX_W-1:0]      edge_from [$];
    logic [bfsp_pkg::VERTEX_W-1:0]      edge_to   [$];
    logic signed [bfsp_pkg::DIST_W-1:0] edge_wt   [$];
    logic signed [bfsp_pkg::DIST_W-1:0] path_dist [MAX_VERTICES];
    bit                                 path_seen [MAX_VERTICES];
    vertex_result_t                     result_q  [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    bellman_ford_shortest_paths_unit #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // count register clamped to 1..MAX_VERTICES
    function automatic int vertices_in_use();
        int n;
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        return n;
    endfunction

    function automatic logic signed [bfsp_pkg::DIST_W-1:0] sat_sum(
        logic signed [bfsp_pkg::DIST_W-1:0] a,
        logic signed [bfsp_pkg::DIST_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'($signed(bfsp_pkg::DIST_MAX))) return bfsp_pkg::DIST_MAX;
        if (s < longint'($signed(bfsp_pkg::DIST_MIN))) return bfsp_pkg::DIST_MIN;
        return s[bfsp_pkg::DIST_W-1:0];
    endfunction

    // true if edge j improves its destination; updates it when apply is set
    function automatic bit try_relax(int j, int n, bit apply);
        logic signed [bfsp_pkg::DIST_W-1:0] cand;
        if (int'(edge_from[j]) >= n || int'(edge_to[j]) >= n) return 1'b0;
        if (!path_seen[edge_from[j]]) return 1'b0;
        cand = sat_sum(path_dist[edge_from[j]], edge_wt[j]);
        if (path_seen[edge_to[j]] && cand >= path_dist[edge_to[j]]) return 1'b0;
        if (apply) begin
            path_dist[edge_to[j]] = cand;
            path_seen[edge_to[j]] = 1'b1;
        end
        return 1'b1;
    endfunction

    // edges past the store's capacity are dropped
    function automatic void log_edge(logic [bfsp_pkg::VERTEX_W-1:0] a,
                                     logic [bfsp_pkg::VERTEX_W-1:0] b,
                                     logic [15:0] w);
        logic signed [bfsp_pkg::DIST_W-1:0] wx;
        wx = $signed(w);
        if (edge_from.size() < MAX_EDGES) begin
            edge_from.insert(edge_from.size(), a);
            edge_to.insert(edge_to.size(), b);
            edge_wt.insert(edge_wt.size(), wx);
        end
    endfunction

    // full run on the stored edges; queues one result per vertex
    function automatic void solve_graph();
        int n;
        bit cyc;
        vertex_result_t r;
        n = vertices_in_use();
        for (int j = 0; j < n; j++) begin
            path_dist[j] = '0;
            path_seen[j] = 1'b0;
        end
        cyc = 1'b0;
        if (int'(source_reg) < n) path_seen[source_reg] = 1'b1;
        for (int p = 1; p < n; p++)
            for (int j = 0; j < edge_from.size(); j++)
                void'(try_relax(j, n, 1'b1));
        for (int j = 0; j < edge_from.size(); j++)
            if (try_relax(j, n, 1'b0)) cyc = 1'b1;
        for (int i = 0; i < n; i++) begin
            r.vtx   = i[bfsp_pkg::VERTEX_W-1:0];
            r.plen  = path_seen[i] ? path_dist[i] : '0;
            r.reach = path_seen[i];
            r.cycle = cyc;
            r.last  = (i == n - 1);
            result_q.insert(result_q.size(), r);
        end
        edge_from.delete();
        edge_to.delete();
        edge_wt.delete();
    endfunction

    // hand-written outcome, same on every vertex of the run
    function automatic void expect_uniform(logic signed [bfsp_pkg::DIST_W-1:0] d,
                                           logic rch, logic cyc);
        int n;
        vertex_result_t r;
        n = vertices_in_use();
        for (int i = 0; i < n; i++) begin
            r.vtx   = i[bfsp_pkg::VERTEX_W-1:0];
            r.plen  = d;
            r.reach = rch;
            r.cycle = cyc;
            r.last  = (i == n - 1);
            result_q.insert(result_q.size(), r);
        end
        edge_from.delete();
        edge_to.delete();
        edge_wt.delete();
    endfunction

    // ---------------------------------------------------------------- drivers

    // mostly an in-range endpoint, sometimes anything the field holds
    function automatic logic [bfsp_pkg::VERTEX_W-1:0] pick_vertex(int n);
        int v;
        v = ($urandom_range(99) < 88) ? int'($urandom_range(n - 1)) : int'($urandom_range(63));
        return v[bfsp_pkg::VERTEX_W-1:0];
    endfunction

    // presents one edge beat and returns at the edge where it is taken
    task automatic offer_edge(logic [bfsp_pkg::VERTEX_W-1:0] a,
                              logic [bfsp_pkg::VERTEX_W-1:0] b,
                              logic [15:0] w, logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - 12 - WEIGHT_BITS){1'b0}}, w, b, a};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // lets every expected beat drain, then gives the sequencer time to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [bfsp_pkg::CFG_IDX_W-1:0] idx,
                             logic [bfsp_pkg::COUNT_W-1:0] val);
        settle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bfsp_pkg::CFG_VERTEX_COUNT) count_reg = val;
        else source_reg = val[bfsp_pkg::VERTEX_W-1:0];
        @(posedge aclk);
    endtask

    function automatic stim_row_t cfg_row(logic [bfsp_pkg::CFG_IDX_W-1:0] idx,
                                          logic [bfsp_pkg::COUNT_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t link_row(logic [bfsp_pkg::VERTEX_W-1:0] a,
                                           logic [bfsp_pkg::VERTEX_W-1:0] b,
                                           logic [15:0] w, logic last);
        stim_row_t r;
        r = '0;
        r.kind   = ROW_EDGE;
        r.from_v = a;
        r.to_v   = b;
        r.wt     = w;
        r.last   = last;
        return r;
    endfunction

    function automatic stim_row_t fixed_row(logic [bfsp_pkg::VERTEX_W-1:0] a,
                                            logic [bfsp_pkg::VERTEX_W-1:0] b,
                                            logic [15:0] w,
                                            logic signed [bfsp_pkg::DIST_W-1:0] d,
                                            logic rch, logic cyc);
        stim_row_t r;
        r = link_row(a, b, w, 1'b1);
        r.typed   = 1'b1;
        r.t_dist  = d;
        r.t_reach = rch;
        r.t_cycle = cyc;
        return r;
    endfunction

    // ---------------------------------------------------------------- receiver side

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // compares each result beat with the oldest expectation
    always @(posedge aclk) begin
        vertex_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat: vertex %0d distance %0d",
                             m_tdata[5:0], $signed(m_tdata[37:6]));
            end else begin
                want = result_q.pop_front();
                if (m_tdata[5:0] !== want.vtx || m_tdata[37:6] !== want.plen ||
                    m_tuser[0] !== want.reach || m_tuser[1] !== want.cycle ||
                    m_tlast !== want.last) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: expected v%0d d%0d r%0b c%0b l%0b, ",
                                  "got v%0d d%0d r%0b c%0b l%0b"},
                                 want.vtx, want.plen, want.reach, want.cycle, want.last,
                                 m_tdata[5:0], $signed(m_tdata[37:6]), m_tuser[0],
                                 m_tuser[1], m_tlast);
                end
            end
        end
    end

    // watchdog: cycles in a row with no beat on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        stim_row_t                     dir_rows [$];
        stim_row_t                     row;
        int                            ph, phase_items, n, e_cnt, wmode, k, r, v, wi;
        logic [bfsp_pkg::VERTEX_W-1:0] a, b;
        logic [15:0]                   w;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows = '{
            // after reset: 64 vertices, source 0; weight extremes round a cycle
            link_row(6'd0,  6'd1,  16'h7FFF, 1'b0),
            link_row(6'd1,  6'd63, 16'h8000, 1'b0),
            link_row(6'd63, 6'd0,  16'hFFFF, 1'b1),
            // count 0 clamps to one vertex: only self-loops and skipped edges
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd0),
            fixed_row(6'd0,  6'd0, 16'h8000, 32'sd0, 1'b1, 1'b1),
            fixed_row(6'd0,  6'd0, 16'h7FFF, 32'sd0, 1'b1, 1'b0),
            fixed_row(6'd63, 6'd0, 16'h8000, 32'sd0, 1'b1, 1'b0),
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd1),
            fixed_row(6'd0,  6'd0, 16'h0000, 32'sd0, 1'b1, 1'b0),
            // source beyond the vertex count reaches nothing
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd10),
            cfg_row(bfsp_pkg::CFG_SOURCE_VERTEX, 7'd63),
            link_row(6'd63, 6'd5, 16'hFFFB, 1'b0),
            fixed_row(6'd0, 6'd5, 16'h0007, 32'sd0, 1'b0, 1'b0),
            // small graph with an out-of-range destination
            cfg_row(bfsp_pkg::CFG_SOURCE_VERTEX, 7'd3),
            link_row(6'd3, 6'd4,  16'd100,  1'b0),
            link_row(6'd4, 6'd9,  16'hFFD8, 1'b0),
            link_row(6'd9, 6'd4,  16'd50,   1'b0),
            link_row(6'd3, 6'd12, 16'd1,    1'b0),
            link_row(6'd3, 6'd9,  16'd200,  1'b1),
            // counts above the maximum clamp to 64
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd127),
            cfg_row(bfsp_pkg::CFG_SOURCE_VERTEX, 7'd0),
            link_row(6'd0,  6'd63, 16'h7FFF, 1'b0),
            link_row(6'd63, 6'd62, 16'h7FFF, 1'b1),
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd65),
            link_row(6'd62, 6'd63, 16'hFFFF, 1'b1),
            cfg_row(bfsp_pkg::CFG_VERTEX_COUNT, 7'd2),
            cfg_row(bfsp_pkg::CFG_SOURCE_VERTEX, 7'd1),
            link_row(6'd1, 6'd0, 16'hFFFF, 1'b1)
        };

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_edge(row.from_v, row.to_v, row.wt, row.last);
                log_edge(row.from_v, row.to_v, row.wt);
                if (row.last) begin
                    if (row.typed) expect_uniform(row.t_dist, row.t_reach, row.t_cycle);
                    else solve_graph();
                end
            end
        end

        // random graphs under four idling patterns
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(1) == 1) begin
                    r = $urandom_range(99);
                    if (r < 45)      v = $urandom_range(8, 1);
                    else if (r < 75) v = $urandom_range(24, 9);
                    else if (r < 85) v = $urandom_range(63, 25);
                    else if (r < 92) v = 64;
                    else if (r < 95) v = 0;
                    else             v = $urandom_range(127, 65);
                    write_reg(bfsp_pkg::CFG_VERTEX_COUNT, v[bfsp_pkg::COUNT_W-1:0]);
                end
                if ($urandom_range(1) == 1) begin
                    n = vertices_in_use();
                    v = ($urandom_range(4) == 0) ? int'($urandom_range(63))
                                                 : int'($urandom_range(n - 1));
                    write_reg(bfsp_pkg::CFG_SOURCE_VERTEX, v[bfsp_pkg::COUNT_W-1:0]);
                end
                n = vertices_in_use();
                // big vertex counts cost a pass per vertex, so keep their edge lists short
                e_cnt = (n > 20) ? int'($urandom_range(8, 1)) : int'($urandom_range(16, 1));
                // 0: non-negative weights, 1: small mixed, 2: anything incl. extremes
                wmode = $urandom_range(2);
                for (k = 0; k < e_cnt; k++) begin
                    a = pick_vertex(n);
                    if ($urandom_range(3) == 0) a = source_reg;
                    b = pick_vertex(n);
                    case (wmode)
                        0: wi = $urandom_range(1000);
                        1: wi = int'($urandom_range(1300)) - 300;
                        default: begin
                            r = $urandom_range(9);
                            if (r == 0)      wi = 32'h8000;
                            else if (r == 1) wi = 32'h7FFF;
                            else             wi = $urandom_range(65535);
                        end
                    endcase
                    w = wi[15:0];
                    offer_edge(a, b, w, k == e_cnt - 1);
                    log_edge(a, b, w);
                end
                phase_items += e_cnt;
                solve_graph();
            end
        end

        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (err_count == 0 && result_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
